@@ src/assert_macros.svh @@
// Assertion macros used by the RTL of the speed regulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ src/dwpi_pkg.sv @@
// Package: widths, reset values, register codes and microcode for the speed regulator.
`timescale 1ns / 1ps
`default_nettype none

package dwpi_pkg;

    localparam int FRAC_BITS = 8;

    localparam int GAIN_W   = 16;
    localparam int LIMIT_W  = 15;
    localparam int SPEED_W  = 16;
    localparam int TIME_W   = 32;
    localparam int HALF_W   = TIME_W / 2;
    localparam int CMD_W    = 24;
    localparam int ERR_W    = SPEED_W + 1;
    localparam int INTEG_W  = 16;
    localparam int ACC_W    = ERR_W + 1;
    localparam int MUL_A_W  = 32;
    localparam int MUL_B_W  = GAIN_W + 1;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int P_W      = GAIN_W + ERR_W + 1;
    localparam int GI_W     = 32;
    localparam int PART_W   = GI_W + HALF_W;
    localparam int T_W      = P_W + 1;
    localparam int SUM_W    = PART_W + 1;

    localparam int NUM_WHEELS  = 2;
    localparam int WHEEL_RIGHT = 0;
    localparam int WHEEL_LEFT  = 1;

    // Reset values follow FRAC_BITS: gains masked to 16 bits, clamp saturated.
    localparam int LIMIT_RST_RAW = 10 << FRAC_BITS;
    localparam int LIMIT_MAX     = (1 << LIMIT_W) - 1;
    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = GAIN_W'(10 << FRAC_BITS);
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST = GAIN_W'(2 << FRAC_BITS);
    localparam logic [LIMIT_W-1:0] INT_LIMIT_RST  =
        LIMIT_W'((LIMIT_RST_RAW > LIMIT_MAX) ? LIMIT_MAX : LIMIT_RST_RAW);

    localparam logic signed [CMD_W-1:0] CMD_MAX = {1'b0, {(CMD_W-1){1'b1}}};
    localparam logic signed [CMD_W-1:0] CMD_MIN = {1'b1, {(CMD_W-1){1'b0}}};

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN  = 2'd0,
        CFG_INTEG_GAIN = 2'd1,
        CFG_INT_LIMIT  = 2'd2
    } cfg_reg_t;

    // Sequencer steps.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;
    localparam logic [STEP_W-1:0] STEP_KP   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_KI   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_DTLO = 3'd3;
    localparam logic [STEP_W-1:0] STEP_DTHI = 3'd4;
    localparam logic [STEP_W-1:0] STEP_OUT  = 3'd5;

    typedef enum logic [2:0] {
        MUL_NONE    = 3'd0,
        MUL_KP_ERR  = 3'd1,
        MUL_KI_INT  = 3'd2,
        MUL_GI_DTLO = 3'd3,
        MUL_GI_DTHI = 3'd4
    } mul_op_t;

    typedef enum logic [1:0] {
        HOLD_NONE = 2'd0,
        HOLD_IN   = 2'd1,
        HOLD_OUT  = 2'd2
    } hold_t;

    typedef struct packed {
        logic              capture;
        logic              integ_upd;
        logic              t_upd;
        logic              out_ld;
        mul_op_t           mul_op;
        hold_t             hold;
        logic              jump;
        logic [STEP_W-1:0] target;
    } ctl_t;

    // Control store: one word per step.
    function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
        ctl_t c;
        c.capture   = 1'b0;
        c.integ_upd = 1'b0;
        c.t_upd     = 1'b0;
        c.out_ld    = 1'b0;
        c.mul_op    = MUL_NONE;
        c.hold      = HOLD_NONE;
        c.jump      = 1'b0;
        c.target    = STEP_IDLE;
        unique case (step)
            STEP_IDLE:
            begin
                c.capture = 1'b1;
                c.hold    = HOLD_IN;
            end
            STEP_KP:
            begin
                c.integ_upd = 1'b1;
                c.mul_op    = MUL_KP_ERR;
            end
            STEP_KI:
            begin
                c.mul_op = MUL_KI_INT;
            end
            STEP_DTLO:
            begin
                c.mul_op = MUL_GI_DTLO;
            end
            STEP_DTHI:
            begin
                c.mul_op = MUL_GI_DTHI;
                c.t_upd  = 1'b1;
            end
            STEP_OUT:
            begin
                c.out_ld = 1'b1;
                c.hold   = HOLD_OUT;
                c.jump   = 1'b1;
                c.target = STEP_IDLE;
            end
            default:
            begin
                c.jump   = 1'b1;
                c.target = STEP_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ src/dwpi_channels.sv @@
// Interfaces: sample, command and configuration channels of the speed regulator.
`timescale 1ns / 1ps
`default_nettype none

interface dwpi_sample_if;
    logic                                     valid;
    logic                                     ready;
    logic        [dwpi_pkg::TIME_W-1:0]       timestamp;
    logic signed [dwpi_pkg::SPEED_W-1:0]      right_ref;
    logic signed [dwpi_pkg::SPEED_W-1:0]      left_ref;
    logic signed [dwpi_pkg::SPEED_W-1:0]      right_speed;
    logic signed [dwpi_pkg::SPEED_W-1:0]      left_speed;

    modport source (output valid, timestamp, right_ref, left_ref, right_speed, left_speed,
                    input ready);
    modport sink   (input valid, timestamp, right_ref, left_ref, right_speed, left_speed,
                    output ready);
endinterface

interface dwpi_command_if;
    logic                                valid;
    logic                                ready;
    logic signed [dwpi_pkg::CMD_W-1:0]   right_command;
    logic signed [dwpi_pkg::CMD_W-1:0]   left_command;

    modport source (output valid, right_command, left_command, input ready);
    modport sink   (input valid, right_command, left_command, output ready);
endinterface

interface dwpi_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [dwpi_pkg::CFG_IDX_W-1:0]      index;
    logic [dwpi_pkg::GAIN_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/dual_wheel_pi_speed_regulator_core.sv @@
// Top level: two-wheel PI speed regulator driven by a microcoded sequencer.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Two-wheel PI speed regulator. Each sample transaction carries a Q16.16
// timestamp and, per wheel, a Q7.8 reference and measured speed; each one
// yields exactly one command transaction with a saturated Q15.8 command per
// wheel: kp*err + ki*integ*dt, floored to the command fraction, where integ
// is the running error sum clamped to +/- int_limit and dt is the timestamp
// delta (mod 2^32) since the previous sample (from timestamp 0 after reset).
// A sample runs through a capture step, four passes through each wheel's
// 32x17 multiplier (kp*err, ki*integ, then that product times the low and
// the high half of dt), and an add/floor/saturate step that loads the
// output register. The next sample is taken the cycle after the result
// loads, and a result not yet taken holds the sequencer at its last step.
// Both wheels run side by side on the same control word. Configuration
// writes (index 0 prop_gain, 1 integ_gain, 2 int_limit; others ignored) are
// always ready and must only be issued while the block is idle.
module dual_wheel_pi_speed_regulator_core (
    input  wire                 clk,
    input  wire                 rst_n,
    dwpi_sample_if.sink         sample,
    dwpi_command_if.source      command,
    dwpi_cfg_if.sink            cfg
);

    localparam int NW = dwpi_pkg::NUM_WHEELS;

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    logic [dwpi_pkg::STEP_W-1:0] pc_reg, pc_next;
    dwpi_pkg::ctl_t              ctl;
    logic                        go;
    logic                        out_free;
    logic                        accept;
    logic                        out_fire;

    assign ctl = dwpi_pkg::ucode(pc_reg);

    always_comb
    begin
        unique case (ctl.hold)
            dwpi_pkg::HOLD_IN:  go = sample.valid;
            dwpi_pkg::HOLD_OUT: go = out_free;
            default:            go = 1'b1;
        endcase
    end

    always_comb
    begin
        if (!go)
        begin
            pc_next = pc_reg;
        end
        else if (ctl.jump)
        begin
            pc_next = ctl.target;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    assign sample.ready = ctl.capture;
    assign accept       = sample.valid & ctl.capture;
    assign out_fire     = ctl.out_ld & go;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [dwpi_pkg::GAIN_W-1:0]  prop_gain_reg;
    logic [dwpi_pkg::GAIN_W-1:0]  integ_gain_reg;
    logic [dwpi_pkg::LIMIT_W-1:0] int_limit_reg;

    assign cfg.ready = 1'b1;

    // ---------------------------------------------------------------
    // Per-wheel datapath
    // ---------------------------------------------------------------
    logic signed [dwpi_pkg::SPEED_W-1:0] lane_ref  [NW];
    logic signed [dwpi_pkg::SPEED_W-1:0] lane_meas [NW];

    assign lane_ref[dwpi_pkg::WHEEL_RIGHT]  = sample.right_ref;
    assign lane_ref[dwpi_pkg::WHEEL_LEFT]   = sample.left_ref;
    assign lane_meas[dwpi_pkg::WHEEL_RIGHT] = sample.right_speed;
    assign lane_meas[dwpi_pkg::WHEEL_LEFT]  = sample.left_speed;

    logic        [dwpi_pkg::TIME_W-1:0]  prev_time_reg;
    logic        [dwpi_pkg::TIME_W-1:0]  dt_reg;
    logic signed [dwpi_pkg::ERR_W-1:0]   err_reg   [NW];
    logic signed [dwpi_pkg::INTEG_W-1:0] integ_reg [NW];
    logic signed [dwpi_pkg::P_W-1:0]     p_reg     [NW];
    logic signed [dwpi_pkg::GI_W-1:0]    gi_reg    [NW];
    logic signed [dwpi_pkg::PART_W-1:0]  lo_reg    [NW];
    logic signed [dwpi_pkg::PART_W-1:0]  hi_reg    [NW];
    logic signed [dwpi_pkg::T_W-1:0]     t_reg     [NW];
    logic signed [dwpi_pkg::CMD_W-1:0]   cmd_reg   [NW];
    logic                                out_valid_reg;

    logic signed [dwpi_pkg::ERR_W-1:0]   err_next   [NW];
    logic signed [dwpi_pkg::ACC_W-1:0]   acc_sum    [NW];
    logic signed [dwpi_pkg::INTEG_W-1:0] integ_next [NW];
    logic signed [dwpi_pkg::MUL_A_W-1:0] mul_a      [NW];
    logic signed [dwpi_pkg::MUL_B_W-1:0] mul_b      [NW];
    logic signed [dwpi_pkg::PROD_W-1:0]  prod       [NW];
    logic signed [dwpi_pkg::T_W-1:0]     t_next     [NW];
    logic signed [dwpi_pkg::SUM_W-1:0]   sum        [NW];
    logic signed [dwpi_pkg::SUM_W-1:0]   sum_shr    [NW];
    logic signed [dwpi_pkg::CMD_W-1:0]   cmd_next   [NW];
    logic signed [dwpi_pkg::ACC_W-1:0]   lim_pos;
    logic signed [dwpi_pkg::ACC_W-1:0]   lim_neg;

    assign lim_pos = $signed({3'b000, int_limit_reg});
    assign lim_neg = -lim_pos;

    always_comb
    begin
        for (int w = 0; w < NW; w++)
        begin
            err_next[w] = dwpi_pkg::ERR_W'(lane_ref[w]) - dwpi_pkg::ERR_W'(lane_meas[w]);

            // integrator: add error, clamp to +/- limit
            acc_sum[w] = dwpi_pkg::ACC_W'(integ_reg[w]) + dwpi_pkg::ACC_W'(err_reg[w]);
            priority if (acc_sum[w] > lim_pos)
            begin
                integ_next[w] = dwpi_pkg::INTEG_W'(lim_pos);
            end
            else if (acc_sum[w] < lim_neg)
            begin
                integ_next[w] = dwpi_pkg::INTEG_W'(lim_neg);
            end
            else
            begin
                integ_next[w] = dwpi_pkg::INTEG_W'(acc_sum[w]);
            end

            // shared multiplier operand select
            unique case (ctl.mul_op)
                dwpi_pkg::MUL_KP_ERR:
                begin
                    mul_a[w] = dwpi_pkg::MUL_A_W'(err_reg[w]);
                    mul_b[w] = $signed({1'b0, prop_gain_reg});
                end
                dwpi_pkg::MUL_KI_INT:
                begin
                    mul_a[w] = dwpi_pkg::MUL_A_W'(integ_reg[w]);
                    mul_b[w] = $signed({1'b0, integ_gain_reg});
                end
                dwpi_pkg::MUL_GI_DTLO:
                begin
                    mul_a[w] = gi_reg[w];
                    mul_b[w] = $signed({1'b0, dt_reg[dwpi_pkg::HALF_W-1:0]});
                end
                dwpi_pkg::MUL_GI_DTHI:
                begin
                    mul_a[w] = gi_reg[w];
                    mul_b[w] = $signed({1'b0, dt_reg[dwpi_pkg::TIME_W-1:dwpi_pkg::HALF_W]});
                end
                default:
                begin
                    mul_a[w] = '0;
                    mul_b[w] = '0;
                end
            endcase
            prod[w] = mul_a[w] * mul_b[w];

            // floor(i / 2^16) = hi + floor(lo / 2^16); fold in the P term early
            t_next[w] = dwpi_pkg::T_W'(p_reg[w])
                      + dwpi_pkg::T_W'(lo_reg[w] >>> dwpi_pkg::HALF_W);

            // final floor to command fraction, then saturate
            sum[w]     = dwpi_pkg::SUM_W'(hi_reg[w]) + dwpi_pkg::SUM_W'(t_reg[w]);
            sum_shr[w] = sum[w] >>> dwpi_pkg::FRAC_BITS;
            priority if (sum_shr[w] > dwpi_pkg::SUM_W'(dwpi_pkg::CMD_MAX))
            begin
                cmd_next[w] = dwpi_pkg::CMD_MAX;
            end
            else if (sum_shr[w] < dwpi_pkg::SUM_W'(dwpi_pkg::CMD_MIN))
            begin
                cmd_next[w] = dwpi_pkg::CMD_MIN;
            end
            else
            begin
                cmd_next[w] = dwpi_pkg::CMD_W'(sum_shr[w]);
            end
        end
    end

    assign out_free = !out_valid_reg || command.ready;

    // ---------------------------------------------------------------
    // Control and architectural state
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= dwpi_pkg::STEP_IDLE;
            out_valid_reg  <= 1'b0;
            prop_gain_reg  <= dwpi_pkg::PROP_GAIN_RST;
            integ_gain_reg <= dwpi_pkg::INTEG_GAIN_RST;
            int_limit_reg  <= dwpi_pkg::INT_LIMIT_RST;
            prev_time_reg  <= '0;
            for (int w = 0; w < NW; w++)
            begin
                integ_reg[w] <= '0;
            end
        end
        else
        begin
            pc_reg <= pc_next;

            if (out_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (command.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg.valid)
            begin
                unique case (cfg.index)
                    dwpi_pkg::CFG_PROP_GAIN:  prop_gain_reg  <= cfg.data;
                    dwpi_pkg::CFG_INTEG_GAIN: integ_gain_reg <= cfg.data;
                    dwpi_pkg::CFG_INT_LIMIT:  int_limit_reg  <= dwpi_pkg::LIMIT_W'(cfg.data);
                    default:                  ;
                endcase
            end

            if (accept)
            begin
                prev_time_reg <= sample.timestamp;
            end

            if (ctl.integ_upd)
            begin
                for (int w = 0; w < NW; w++)
                begin
                    integ_reg[w] <= integ_next[w];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Working registers (no reset)
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dt_reg <= sample.timestamp - prev_time_reg;
        end
        for (int w = 0; w < NW; w++)
        begin
            if (accept)
            begin
                err_reg[w] <= err_next[w];
            end
            unique case (ctl.mul_op)
                dwpi_pkg::MUL_KP_ERR:  p_reg[w]  <= dwpi_pkg::P_W'(prod[w]);
                dwpi_pkg::MUL_KI_INT:  gi_reg[w] <= dwpi_pkg::GI_W'(prod[w]);
                dwpi_pkg::MUL_GI_DTLO: lo_reg[w] <= dwpi_pkg::PART_W'(prod[w]);
                dwpi_pkg::MUL_GI_DTHI: hi_reg[w] <= dwpi_pkg::PART_W'(prod[w]);
                default:               ;
            endcase
            if (ctl.t_upd)
            begin
                t_reg[w] <= t_next[w];
            end
            if (out_fire)
            begin
                cmd_reg[w] <= cmd_next[w];
            end
        end
    end

    assign command.valid         = out_valid_reg;
    assign command.right_command = cmd_reg[dwpi_pkg::WHEEL_RIGHT];
    assign command.left_command  = cmd_reg[dwpi_pkg::WHEEL_LEFT];

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // right after the integrator update, both integrators sit inside the clamp
    `ASSERT_CLK(a_integ_clamped, (pc_reg == dwpi_pkg::STEP_KI) |-> (integ_reg[0] <= lim_pos) && (integ_reg[0] >= lim_neg) && (integ_reg[1] <= lim_pos) && (integ_reg[1] >= lim_neg), "integrator outside clamp after update")
    // a new result only appears from the output step
    `ASSERT_CLK(a_result_origin, $rose(command.valid) |-> ($past(pc_reg) == dwpi_pkg::STEP_OUT), "result raised outside output step")
    // a stalled result holds the sequencer and keeps its value
    `ASSERT_CLK(a_stall_holds, (pc_reg == dwpi_pkg::STEP_OUT) && command.valid && !command.ready |=> (pc_reg == dwpi_pkg::STEP_OUT) && $stable(command.right_command) && $stable(command.left_command), "stalled result overwritten")
    // step counter stays inside the program
    `ASSERT_NEVER(a_pc_range, pc_reg > dwpi_pkg::STEP_OUT, "step counter outside program")

endmodule

`default_nettype wire
